// ===== rtl/sff_pkg.sv =====
package sff_pkg;

	typedef struct packed {
		logic signed [31:0] steering_cmd;
		logic signed [31:0] steering_meas;
		logic signed [31:0] wheel_fl;
		logic signed [31:0] wheel_fr;
		logic signed [31:0] wheel_rl;
		logic signed [31:0] wheel_rr;
		logic signed [31:0] long_accel;
		logic signed [31:0] yaw_rate;
		logic signed [31:0] frame_latency;
	} in_t;

	typedef struct packed {
		logic signed [31:0] center_torque;
		logic signed [31:0] left_cue;
		logic signed [31:0] right_cue;
		logic signed [31:0] mean_speed;
	} out_t;

	typedef struct packed {
		logic [30:0] latency_limit;
		logic [30:0] slew_speed;
		logic [31:0] center_gain;
		logic [31:0] damp_gain;
		logic [31:0] speed_weight;
		logic [31:0] accel_weight;
		logic [31:0] yaw_weight;
		logic [30:0] torque_limit;
	} cfg_t;

	typedef enum logic [2:0] {
		REG_LATENCY_LIMIT = 3'd0,
		REG_SLEW_SPEED    = 3'd1,
		REG_CENTER_GAIN   = 3'd2,
		REG_DAMP_GAIN     = 3'd3,
		REG_SPEED_WEIGHT  = 3'd4,
		REG_ACCEL_WEIGHT  = 3'd5,
		REG_YAW_WEIGHT    = 3'd6,
		REG_TORQUE_LIMIT  = 3'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FRONT,
		ST_FILT,
		ST_EMIT
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_MUL,
		OP_MARGIN,
		OP_ERR,
		OP_DAMP,
		OP_MQ_WB,
		OP_SLEW,
		OP_DIFF_ACC,
		OP_FIX50,
		OP_SUM,
		OP_FIX18,
		OP_DIFF_YAW,
		OP_CUE_OUT,
		OP_EMIT
	} op_t;

	typedef enum logic [2:0] {
		MS_MARGIN,
		MS_DAMP,
		MS_HI,
		MS_LO,
		MS_DIV50,
		MS_DIV18
	} msel_t;

	typedef enum logic [1:0] {
		SRC_X,
		SRC_ACC,
		SRC_SPD,
		SRC_YAW
	} src_t;

	typedef enum logic [2:0] {
		G_CENTER,
		G_DAMP,
		G_SPEED,
		G_ACCEL,
		G_YAW,
		G_TENTH,
		G_HUND
	} gsel_t;

	typedef enum logic [3:0] {
		DST_TORQUE,
		DST_X,
		DST_DAMP,
		DST_ACC,
		DST_SPD,
		DST_YAW,
		DST_CUE_SET,
		DST_CUE_SUB,
		DST_CUE_YAW
	} dst_t;

	typedef struct packed {
		op_t   op;
		msel_t msel;
		src_t  src;
		gsel_t gsel;
		dst_t  dst;
		logic  side;
	} cmd_t;

	localparam logic [3:0] FRONT_LAST = 4'd14;
	localparam logic [4:0] FILT_LAST  = 5'd26;

	localparam int K_NOTCH_STEP = 13107;
	localparam int K_DAMP_CLAMP = 6554;
	localparam logic [31:0] K_TENTH_Q24     = 32'd1677722;
	localparam logic [31:0] K_HUNDREDTH_Q24 = 32'd167772;
	// floor(2^37/50) and floor(2^36/18), quotient off by at most one
	localparam logic [31:0] K_RECIP50 = 32'd2748779069;
	localparam logic [31:0] K_RECIP18 = 32'd3817748707;

	function automatic logic signed [31:0] sat32(input logic signed [58:0] v);
		logic signed [31:0] res;
		if (v > 59'sd2147483647)
			res = 32'sh7FFFFFFF;
		else if (v < -59'sd2147483648)
			res = 32'sh80000000;
		else
			res = v[31:0];
		return res;
	endfunction

	function automatic cmd_t make_cmd(input op_t op, input msel_t ms, input src_t src,
		input gsel_t g, input dst_t d, input logic side);
		cmd_t c;
		c.op   = op;
		c.msel = ms;
		c.src  = src;
		c.gsel = g;
		c.dst  = d;
		c.side = side;
		return c;
	endfunction

	function automatic cmd_t front_cmd(input logic [3:0] step);
		cmd_t c;
		c = make_cmd(OP_NONE, MS_HI, SRC_X, G_TENTH, DST_X, 1'b0);
		unique case (step)
			4'd0:  c.op = OP_LOAD;
			4'd1:  c = make_cmd(OP_MUL, MS_MARGIN, SRC_X, G_CENTER, DST_X, 1'b0);
			4'd2:  c.op = OP_MARGIN;
			4'd3:  c.op = OP_ERR;
			4'd4:  c = make_cmd(OP_MUL, MS_HI, SRC_X, G_CENTER, DST_X, 1'b0);
			4'd5:  c = make_cmd(OP_MUL, MS_LO, SRC_X, G_CENTER, DST_X, 1'b0);
			4'd6:  c = make_cmd(OP_MQ_WB, MS_HI, SRC_X, G_CENTER, DST_TORQUE, 1'b0);
			4'd7:  c = make_cmd(OP_MUL, MS_DAMP, SRC_X, G_HUND, DST_X, 1'b0);
			4'd8:  c.op = OP_DAMP;
			4'd9:  c = make_cmd(OP_MUL, MS_HI, SRC_X, G_HUND, DST_X, 1'b0);
			4'd10: c = make_cmd(OP_MUL, MS_LO, SRC_X, G_HUND, DST_X, 1'b0);
			4'd11: c = make_cmd(OP_MQ_WB, MS_HI, SRC_X, G_HUND, DST_X, 1'b0);
			4'd12: c = make_cmd(OP_MUL, MS_HI, SRC_X, G_DAMP, DST_X, 1'b0);
			4'd13: c = make_cmd(OP_MUL, MS_LO, SRC_X, G_DAMP, DST_X, 1'b0);
			4'd14: c = make_cmd(OP_MQ_WB, MS_HI, SRC_X, G_DAMP, DST_DAMP, 1'b0);
			default: c.op = OP_NONE;
		endcase
		return c;
	endfunction

	function automatic cmd_t filt_cmd(input logic [4:0] step, input logic side);
		cmd_t c;
		c = make_cmd(OP_NONE, MS_HI, SRC_X, G_TENTH, DST_X, side);
		unique case (step)
			5'd0:  c.op = OP_SLEW;
			5'd1:  c.op = OP_DIFF_ACC;
			5'd2:  c = make_cmd(OP_MUL, MS_HI, SRC_X, G_TENTH, DST_X, side);
			5'd3:  c = make_cmd(OP_MUL, MS_LO, SRC_X, G_TENTH, DST_X, side);
			5'd4:  c = make_cmd(OP_MQ_WB, MS_HI, SRC_X, G_TENTH, DST_ACC, side);
			5'd5:  c = make_cmd(OP_MUL, MS_DIV50, SRC_X, G_TENTH, DST_X, side);
			5'd6:  c.op = OP_FIX50;
			5'd7:  c.op = OP_SUM;
			5'd8:  c = make_cmd(OP_MUL, MS_DIV18, SRC_X, G_TENTH, DST_X, side);
			5'd9:  c.op = OP_FIX18;
			5'd10: c = make_cmd(OP_MUL, MS_HI, SRC_X, G_HUND, DST_X, side);
			5'd11: c = make_cmd(OP_MUL, MS_LO, SRC_X, G_HUND, DST_X, side);
			5'd12: c = make_cmd(OP_MQ_WB, MS_HI, SRC_X, G_HUND, DST_SPD, side);
			5'd13: c.op = OP_DIFF_YAW;
			5'd14: c = make_cmd(OP_MUL, MS_HI, SRC_X, G_TENTH, DST_X, side);
			5'd15: c = make_cmd(OP_MUL, MS_LO, SRC_X, G_TENTH, DST_X, side);
			5'd16: c = make_cmd(OP_MQ_WB, MS_HI, SRC_X, G_TENTH, DST_YAW, side);
			5'd17: c = make_cmd(OP_MUL, MS_HI, SRC_SPD, G_SPEED, DST_X, side);
			5'd18: c = make_cmd(OP_MUL, MS_LO, SRC_SPD, G_SPEED, DST_X, side);
			5'd19: c = make_cmd(OP_MQ_WB, MS_HI, SRC_SPD, G_SPEED, DST_CUE_SET, side);
			5'd20: c = make_cmd(OP_MUL, MS_HI, SRC_ACC, G_ACCEL, DST_X, side);
			5'd21: c = make_cmd(OP_MUL, MS_LO, SRC_ACC, G_ACCEL, DST_X, side);
			5'd22: c = make_cmd(OP_MQ_WB, MS_HI, SRC_ACC, G_ACCEL, DST_CUE_SUB, side);
			5'd23: c = make_cmd(OP_MUL, MS_HI, SRC_YAW, G_YAW, DST_X, side);
			5'd24: c = make_cmd(OP_MUL, MS_LO, SRC_YAW, G_YAW, DST_X, side);
			5'd25: c = make_cmd(OP_MQ_WB, MS_HI, SRC_YAW, G_YAW, DST_CUE_YAW, side);
			5'd26: c.op = OP_CUE_OUT;
			default: c.op = OP_NONE;
		endcase
		return c;
	endfunction

endpackage

// ===== rtl/sff_regs.sv =====
module sff_regs (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [4:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	output sff_pkg::cfg_t    cfg
);

	sff_pkg::cfg_t    cfg_q;
	sff_pkg::reg_idx_t idx;
	logic             wr;

	assign idx    = sff_pkg::reg_idx_t'(paddr[4:2]);
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.latency_limit <= 31'd65536;
			cfg_q.slew_speed    <= 31'd65536;
			cfg_q.center_gain   <= 32'd41943;
			cfg_q.damp_gain     <= 32'd41943;
			cfg_q.speed_weight  <= 32'd168;
			cfg_q.accel_weight  <= 32'd168;
			cfg_q.yaw_weight    <= 32'd168;
			cfg_q.torque_limit  <= 31'd6553600;
		end else if (wr) begin
			unique case (idx)
				sff_pkg::REG_LATENCY_LIMIT: cfg_q.latency_limit <= pwdata[30:0];
				sff_pkg::REG_SLEW_SPEED:    cfg_q.slew_speed    <= pwdata[30:0];
				sff_pkg::REG_CENTER_GAIN:   cfg_q.center_gain   <= pwdata;
				sff_pkg::REG_DAMP_GAIN:     cfg_q.damp_gain     <= pwdata;
				sff_pkg::REG_SPEED_WEIGHT:  cfg_q.speed_weight  <= pwdata;
				sff_pkg::REG_ACCEL_WEIGHT:  cfg_q.accel_weight  <= pwdata;
				sff_pkg::REG_YAW_WEIGHT:    cfg_q.yaw_weight    <= pwdata;
				sff_pkg::REG_TORQUE_LIMIT:  cfg_q.torque_limit  <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			sff_pkg::REG_LATENCY_LIMIT: prdata = {1'b0, cfg_q.latency_limit};
			sff_pkg::REG_SLEW_SPEED:    prdata = {1'b0, cfg_q.slew_speed};
			sff_pkg::REG_CENTER_GAIN:   prdata = cfg_q.center_gain;
			sff_pkg::REG_DAMP_GAIN:     prdata = cfg_q.damp_gain;
			sff_pkg::REG_SPEED_WEIGHT:  prdata = cfg_q.speed_weight;
			sff_pkg::REG_ACCEL_WEIGHT:  prdata = cfg_q.accel_weight;
			sff_pkg::REG_YAW_WEIGHT:    prdata = cfg_q.yaw_weight;
			sff_pkg::REG_TORQUE_LIMIT:  prdata = {1'b0, cfg_q.torque_limit};
			default:                    prdata = '0;
		endcase
	end

endmodule

// ===== rtl/sff_ctrl.sv =====
module sff_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	output sff_pkg::cmd_t cmd
);

	sff_pkg::state_t state_q, state_d;
	logic [3:0]      front_q, front_d;
	logic [4:0]      filt_q, filt_d;
	logic            side_q, side_d;
	logic            out_valid_q;
	logic            emit;
	logic            out_busy;

	assign out_busy  = out_valid_q && out_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		front_d = front_q;
		filt_d  = filt_q;
		side_d  = side_q;
		unique case (state_q)
			sff_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = sff_pkg::ST_FRONT;
					front_d = 4'd1;
				end
			end
			sff_pkg::ST_FRONT: begin
				if (front_q == sff_pkg::FRONT_LAST) begin
					state_d = sff_pkg::ST_FILT;
					filt_d  = '0;
					side_d  = 1'b0;
				end else begin
					front_d = front_q + 4'd1;
				end
			end
			sff_pkg::ST_FILT: begin
				if (filt_q == sff_pkg::FILT_LAST) begin
					filt_d = '0;
					if (side_q)
						state_d = sff_pkg::ST_EMIT;
					else
						side_d = 1'b1;
				end else begin
					filt_d = filt_q + 5'd1;
				end
			end
			sff_pkg::ST_EMIT: begin
				if (!out_busy)
					state_d = sff_pkg::ST_IDLE;
			end
			default: state_d = sff_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = sff_pkg::make_cmd(sff_pkg::OP_NONE, sff_pkg::MS_HI, sff_pkg::SRC_X,
			sff_pkg::G_TENTH, sff_pkg::DST_X, 1'b0);
		in_stall = 1'b1;
		emit     = 1'b0;
		unique case (state_q)
			sff_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid)
					cmd = sff_pkg::front_cmd(4'd0);
			end
			sff_pkg::ST_FRONT: cmd = sff_pkg::front_cmd(front_q);
			sff_pkg::ST_FILT:  cmd = sff_pkg::filt_cmd(filt_q, side_q);
			sff_pkg::ST_EMIT: begin
				if (!out_busy) begin
					emit   = 1'b1;
					cmd.op = sff_pkg::OP_EMIT;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sff_pkg::ST_IDLE;
			front_q     <= '0;
			filt_q      <= '0;
			side_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			front_q <= front_d;
			filt_q  <= filt_d;
			side_q  <= side_d;
			if (emit)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

endmodule

// ===== rtl/sff_dp.sv =====
module sff_dp (
	input  logic          clk,
	input  logic          arst_n,
	input  sff_pkg::cmd_t cmd,
	input  sff_pkg::cfg_t cfg,
	input  sff_pkg::in_t  in_data,
	output sff_pkg::out_t out_data
);

	localparam logic signed [32:0] NOTCH  = 33'(sff_pkg::K_NOTCH_STEP);
	localparam logic signed [58:0] DCLAMP = 59'(sff_pkg::K_DAMP_CLAMP);

	sff_pkg::in_t       in_q;
	sff_pkg::out_t      out_q;
	logic signed [31:0] mean_q;
	logic [30:0]        lat_q;
	logic [45:0]        margin_q;
	logic signed [48:0] x_q;
	logic signed [31:0] torque_q;
	logic signed [31:0] last_cmd_q, acc_lim_q, acc_sm_q, spd_sm_q, yaw_sm_q;
	logic [65:0]        prod_q;
	logic [56:0]        p_q;
	logic [23:0]        lo_q;
	logic               neg_q;
	logic signed [31:0] t_q;
	logic [33:0]        n_q;
	logic               sneg_q;
	logic signed [42:0] sum_q;
	logic signed [31:0] left_q, right_q;

	// shared multiplier
	logic [33:0] mul_a;
	logic [31:0] mul_b;
	logic [65:0] mul_p;
	logic [31:0] gval;
	logic signed [48:0] sval;
	logic [48:0] s_mag;

	logic signed [32:0] dcmd;
	logic [32:0]        dmag;
	logic signed [32:0] acc_ext;
	logic [32:0]        acc_mag;

	always_comb begin
		case (cmd.gsel)
			sff_pkg::G_CENTER: gval = cfg.center_gain;
			sff_pkg::G_DAMP:   gval = cfg.damp_gain;
			sff_pkg::G_SPEED:  gval = cfg.speed_weight;
			sff_pkg::G_ACCEL:  gval = cfg.accel_weight;
			sff_pkg::G_YAW:    gval = cfg.yaw_weight;
			sff_pkg::G_TENTH:  gval = sff_pkg::K_TENTH_Q24;
			sff_pkg::G_HUND:   gval = sff_pkg::K_HUNDREDTH_Q24;
			default:           gval = '0;
		endcase
		case (cmd.src)
			sff_pkg::SRC_X:   sval = x_q;
			sff_pkg::SRC_ACC: sval = 49'(acc_sm_q);
			sff_pkg::SRC_SPD: sval = 49'(spd_sm_q);
			sff_pkg::SRC_YAW: sval = 49'(yaw_sm_q);
			default:          sval = '0;
		endcase
	end

	assign s_mag   = sval[48] ? 49'(-sval) : 49'(sval);
	assign dcmd    = 33'(in_q.steering_cmd) - 33'(last_cmd_q);
	assign dmag    = dcmd[32] ? 33'(-dcmd) : 33'(dcmd);
	assign acc_ext = 33'(acc_sm_q);
	assign acc_mag = acc_ext[32] ? 33'(-acc_ext) : 33'(acc_ext);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.msel)
			sff_pkg::MS_MARGIN: begin
				mul_a = {3'b0, cfg.latency_limit - lat_q};
				mul_b = {1'b0, cfg.slew_speed};
			end
			sff_pkg::MS_DAMP: begin
				mul_a = {1'b0, dmag};
				mul_b = {1'b0, lat_q};
			end
			sff_pkg::MS_HI: begin
				mul_a = {9'b0, s_mag[48:24]};
				mul_b = gval;
			end
			sff_pkg::MS_LO: begin
				mul_a = {10'b0, lo_q};
				mul_b = gval;
			end
			sff_pkg::MS_DIV50: begin
				mul_a = {1'b0, acc_mag};
				mul_b = sff_pkg::K_RECIP50;
			end
			sff_pkg::MS_DIV18: begin
				mul_a = n_q;
				mul_b = sff_pkg::K_RECIP18;
			end
			default: ;
		endcase
	end

	assign mul_p = 66'(mul_a) * 66'(mul_b);

	// load
	logic signed [33:0] wsum, mean34;
	logic [30:0]        lat_c;
	assign wsum = 34'(in_data.wheel_fl) + 34'(in_data.wheel_fr)
		+ 34'(in_data.wheel_rl) + 34'(in_data.wheel_rr);
	assign mean34 = wsum[33] ? ((wsum + 34'sd3) >>> 2) : (wsum >>> 2);
	always_comb begin
		if (in_data.frame_latency[31])
			lat_c = '0;
		else if (in_data.frame_latency[30:0] > cfg.latency_limit)
			lat_c = cfg.latency_limit;
		else
			lat_c = in_data.frame_latency[30:0];
	end

	// deadband error
	logic signed [47:0] diff, mg, err;
	assign diff = 48'(in_q.steering_cmd) - 48'(in_q.steering_meas);
	assign mg   = $signed({2'b0, margin_q});
	always_comb begin
		if (diff > mg)
			err = diff - mg;
		else if (diff < -mg)
			err = diff + mg;
		else
			err = '0;
	end

	// damper product
	logic signed [48:0] pd;
	assign pd = $signed({1'b0, prod_q[63:16]});

	// gain product writeback
	logic [57:0]        r_mag;
	logic signed [58:0] r_s, tl_s, dcl, tsum;
	assign r_mag = 58'(p_q) + 58'(prod_q[65:24]);
	assign r_s   = neg_q ? -$signed({1'b0, r_mag}) : $signed({1'b0, r_mag});
	assign tl_s  = $signed({28'b0, cfg.torque_limit});
	always_comb begin
		if (r_s > DCLAMP)
			dcl = DCLAMP;
		else if (r_s < -DCLAMP)
			dcl = -DCLAMP;
		else
			dcl = r_s;
	end
	assign tsum = 59'(torque_q) + dcl;

	// slew limit
	logic signed [32:0] sd;
	assign sd = 33'(in_q.long_accel) - 33'(acc_lim_q);

	// divide by 50 fixup
	logic [25:0]        q50_0;
	logic [32:0]        m50, rem50;
	logic [26:0]        q50;
	assign q50_0 = prod_q[62:37];
	assign m50   = 33'({q50_0, 5'b0}) + 33'({q50_0, 4'b0}) + 33'({q50_0, 1'b0});
	assign rem50 = acc_mag - m50;
	assign q50   = (rem50 >= 33'd50) ? 27'(q50_0) + 27'd1 : 27'(q50_0);

	// mean plus scaled accel, times five
	logic signed [33:0] ssum;
	logic [33:0]        smag;
	assign ssum = 34'(mean_q) + 34'(t_q);
	assign smag = ssum[33] ? 34'(-ssum) : 34'(ssum);

	// divide by 18 fixup
	logic [29:0]        q18_0;
	logic [33:0]        m18, rem18;
	logic [30:0]        q18;
	logic signed [32:0] tgt;
	assign q18_0 = prod_q[65:36];
	assign m18   = 34'({q18_0, 4'b0}) + 34'({q18_0, 1'b0});
	assign rem18 = n_q - m18;
	assign q18   = (rem18 >= 34'd18) ? 31'(q18_0) + 31'd1 : 31'(q18_0);
	assign tgt   = sneg_q ? $signed({2'b0, q18}) : -$signed({2'b0, q18});

	logic signed [31:0] cue_sat;
	assign cue_sat = sff_pkg::sat32(59'(sum_q));

	// filter and damper state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_cmd_q <= '0;
			acc_lim_q  <= '0;
			acc_sm_q   <= '0;
			spd_sm_q   <= '0;
			yaw_sm_q   <= '0;
		end else begin
			case (cmd.op)
				sff_pkg::OP_DAMP: last_cmd_q <= in_q.steering_cmd;
				sff_pkg::OP_SLEW: begin
					if (sd > NOTCH)
						acc_lim_q <= acc_lim_q + 32'(sff_pkg::K_NOTCH_STEP);
					else if (sd < -NOTCH)
						acc_lim_q <= acc_lim_q - 32'(sff_pkg::K_NOTCH_STEP);
					else
						acc_lim_q <= in_q.long_accel;
				end
				sff_pkg::OP_MQ_WB: begin
					case (cmd.dst)
						sff_pkg::DST_ACC: acc_sm_q <= acc_sm_q + r_s[31:0];
						sff_pkg::DST_SPD: spd_sm_q <= spd_sm_q + r_s[31:0];
						sff_pkg::DST_YAW: yaw_sm_q <= yaw_sm_q + r_s[31:0];
						default: ;
					endcase
				end
				default: ;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			sff_pkg::OP_LOAD: begin
				in_q   <= in_data;
				mean_q <= mean34[31:0];
				lat_q  <= lat_c;
			end
			sff_pkg::OP_MUL: begin
				prod_q <= mul_p;
				if (cmd.msel == sff_pkg::MS_HI) begin
					lo_q  <= s_mag[23:0];
					neg_q <= sval[48];
				end
				if (cmd.msel == sff_pkg::MS_LO)
					p_q <= prod_q[56:0];
			end
			sff_pkg::OP_MARGIN:   margin_q <= prod_q[61:16];
			sff_pkg::OP_ERR:      x_q <= 49'(err);
			sff_pkg::OP_DAMP:     x_q <= dcmd[32] ? -pd : pd;
			sff_pkg::OP_MQ_WB: begin
				case (cmd.dst)
					sff_pkg::DST_TORQUE: begin
						if (r_s > tl_s)
							torque_q <= tl_s[31:0];
						else if (r_s < -tl_s)
							torque_q <= 32'(-tl_s);
						else
							torque_q <= r_s[31:0];
					end
					sff_pkg::DST_X:       x_q <= r_s[48:0];
					sff_pkg::DST_DAMP:    torque_q <= sff_pkg::sat32(tsum);
					sff_pkg::DST_CUE_SET: sum_q <= r_s[42:0];
					sff_pkg::DST_CUE_SUB: sum_q <= sum_q - r_s[42:0];
					sff_pkg::DST_CUE_YAW: begin
						// yaw enters with minus sign on the left pass
						if (cmd.side)
							sum_q <= sum_q + r_s[42:0];
						else
							sum_q <= sum_q - r_s[42:0];
					end
					default: ;
				endcase
			end
			sff_pkg::OP_DIFF_ACC: x_q <= 49'(acc_lim_q) - 49'(acc_sm_q);
			sff_pkg::OP_FIX50: begin
				t_q <= acc_ext[32] ? -$signed({5'b0, q50}) : $signed({5'b0, q50});
			end
			sff_pkg::OP_SUM: begin
				n_q    <= (smag << 2) + smag;
				sneg_q <= ssum[33];
			end
			sff_pkg::OP_FIX18:    x_q <= 49'(tgt) - 49'(spd_sm_q);
			sff_pkg::OP_DIFF_YAW: x_q <= 49'(in_q.yaw_rate) - 49'(yaw_sm_q);
			sff_pkg::OP_CUE_OUT: begin
				if (cmd.side)
					right_q <= cue_sat;
				else
					left_q <= cue_sat;
			end
			sff_pkg::OP_EMIT: begin
				out_q.center_torque <= torque_q;
				out_q.left_cue      <= left_q;
				out_q.right_cue     <= right_q;
				out_q.mean_speed    <= mean_q;
			end
			default: ;
		endcase
	end

	assign out_data = out_q;

endmodule

// ===== rtl/steering_force_feedback_unit.sv =====
// frames are taken only in the idle state, so each frame is finished before the next is taken
// all multiplies run through one 34x32 multiplier, stepped by a sequencer:
// 15 steps for torque and damper, then 27 steps per cue filter pass, twice
// a new frame is taken while the previous result still waits at the output
// reset (async, active low) restores register defaults and clears filter state
module steering_force_feedback_unit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  sff_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_stall,
	output sff_pkg::out_t out_data,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [4:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);

	sff_pkg::cfg_t cfg;
	sff_pkg::cmd_t cmd;

	sff_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	sff_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	sff_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.cfg      (cfg),
		.in_data  (in_data),
		.out_data (out_data)
	);

endmodule

// ===== dv/steering_force_feedback_unit_test.sv =====
`timescale 1ns / 1ps

module steering_force_feedback_unit_test;

	localparam int CYCLE_LIMIT = 400000;

	logic            clk;
	logic            arst_n;
	logic            in_valid;
	logic            in_stall;
	sff_pkg::in_t    in_data;
	logic            out_valid;
	logic            out_stall;
	sff_pkg::out_t   out_data;
	logic            psel;
	logic            penable;
	logic            pwrite;
	logic [4:0]      paddr;
	logic [31:0]     pwdata;
	logic [31:0]     prdata;
	logic            pready;

	steering_force_feedback_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// predictor copy of registers and filter state
	logic [31:0] lat_lim, slew, g_center, g_damp, w_speed, w_accel, w_yaw, trq_lim;
	longint prev_cmd, acc_lim, acc_sm, spd_sm, yaw_sm;

	sff_pkg::out_t frame_q[$];
	int     errors;
	int     cycles;
	int     send_idle, recv_idle;

	typedef struct {
		sff_pkg::in_t  frame;
		bit            known;
		sff_pkg::out_t want;
	} row_t;
	row_t rows[$];

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint gain_mul(longint a, logic [31:0] g);
		logic [63:0] m;
		logic [63:0] r;
		m = (a < 0) ? 64'(-a) : 64'(a);
		if (m > 64'h007F_FFFF_FFFF_FFFF) m = 64'h007F_FFFF_FFFF_FFFF;
		r = (m >> 24) * {32'd0, g} + (((m & 64'hFF_FFFF) * {32'd0, g}) >> 24);
		return (a < 0) ? -longint'(r) : longint'(r);
	endfunction

	function automatic longint cue_step(longint acc_in, longint yaw_in, longint mean,
		longint sgn);
		longint d, target;
		d = acc_in - acc_lim;
		if (d > sff_pkg::K_NOTCH_STEP) acc_lim += sff_pkg::K_NOTCH_STEP;
		else if (d < -sff_pkg::K_NOTCH_STEP) acc_lim -= sff_pkg::K_NOTCH_STEP;
		else acc_lim = acc_in;
		acc_sm += gain_mul(acc_lim - acc_sm, sff_pkg::K_TENTH_Q24);
		target = mean + (acc_sm * 20) / 1000;
		target = -((target * 5) / 18);
		spd_sm += gain_mul(target - spd_sm, sff_pkg::K_HUNDREDTH_Q24);
		yaw_sm += gain_mul(yaw_in - yaw_sm, sff_pkg::K_TENTH_Q24);
		return clamp32(gain_mul(spd_sm, w_speed) - gain_mul(acc_sm, w_accel)
			+ sgn * gain_mul(yaw_sm, w_yaw));
	endfunction

	function automatic sff_pkg::out_t predict_frame(sff_pkg::in_t f);
		longint cmd, lat, lim, margin, diff, err, trq, dcmd, prod, damper, mean;
		logic [63:0] dm;
		sff_pkg::out_t o;
		cmd  = f.steering_cmd;
		mean = (longint'(f.wheel_fl) + f.wheel_fr + f.wheel_rl + f.wheel_rr) / 4;
		lat  = f.frame_latency;
		lim  = {32'd0, lat_lim};
		if (lat < 0) lat = 0;
		if (lat > lim) lat = lim;
		margin = longint'((64'(lim - lat) * {32'd0, slew}) >> 16);
		diff = cmd - longint'(f.steering_meas);
		if (diff > margin) err = diff - margin;
		else if (diff < -margin) err = diff + margin;
		else err = 0;
		trq = gain_mul(err, g_center);
		if (trq > longint'(trq_lim)) trq = trq_lim;
		if (trq < -longint'(trq_lim)) trq = -longint'(trq_lim);
		dcmd = cmd - prev_cmd;
		dm = (dcmd < 0) ? 64'(-dcmd) : 64'(dcmd);
		prod = longint'((64'(lat) * dm) >> 16);
		if (dcmd < 0) prod = -prod;
		damper = gain_mul(gain_mul(prod, sff_pkg::K_HUNDREDTH_Q24), g_damp);
		if (damper > sff_pkg::K_DAMP_CLAMP) damper = sff_pkg::K_DAMP_CLAMP;
		if (damper < -sff_pkg::K_DAMP_CLAMP) damper = -sff_pkg::K_DAMP_CLAMP;
		prev_cmd = cmd;
		o.center_torque = 32'(clamp32(trq + damper));
		o.left_cue   = 32'(cue_step(f.long_accel, f.yaw_rate, mean, -1));
		o.right_cue  = 32'(cue_step(f.long_accel, f.yaw_rate, mean, 1));
		o.mean_speed = 32'(mean);
		return o;
	endfunction

	task automatic write_reg(sff_pkg::reg_idx_t idx, logic [31:0] val);
		psel   <= 1'b1;
		pwrite <= 1'b1;
		paddr  <= 5'(idx) << 2;
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			sff_pkg::REG_LATENCY_LIMIT: lat_lim  = val & 32'h7FFF_FFFF;
			sff_pkg::REG_SLEW_SPEED:    slew     = val & 32'h7FFF_FFFF;
			sff_pkg::REG_CENTER_GAIN:   g_center = val;
			sff_pkg::REG_DAMP_GAIN:     g_damp   = val;
			sff_pkg::REG_SPEED_WEIGHT:  w_speed  = val;
			sff_pkg::REG_ACCEL_WEIGHT:  w_accel  = val;
			sff_pkg::REG_YAW_WEIGHT:    w_yaw    = val;
			sff_pkg::REG_TORQUE_LIMIT:  trq_lim  = val & 32'h7FFF_FFFF;
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (frame_q.size() != 0) @(negedge clk);
		repeat (80) @(negedge clk);
	endtask

	// one frame per call; valid stays high across back-to-back beats
	task automatic send_frame(sff_pkg::in_t f, bit known, sff_pkg::out_t want);
		while (send_idle != 0 && $urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= f;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (known) begin
			void'(predict_frame(f));
			frame_q = {frame_q, want};
		end else begin
			frame_q = {frame_q, predict_frame(f)};
		end
		@(negedge clk);
	endtask

	function automatic logic [31:0] pick_word();
		case ($urandom_range(5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'($signed($urandom_range(2000000)) - 1000000);
			default: return $urandom;
		endcase
	endfunction

	function automatic sff_pkg::in_t rand_frame();
		sff_pkg::in_t f;
		int base;
		base = $signed($urandom_range(200 * 65536)) - 100 * 65536;
		f.steering_cmd  = (($urandom_range(9) == 0)) ? pick_word()
			: base + $signed($urandom_range(65536 * 4));
		f.steering_meas = (($urandom_range(9) == 0)) ? pick_word() : base;
		f.wheel_fl = ($urandom_range(7) == 0) ? pick_word() : $urandom_range(200 * 65536);
		f.wheel_fr = ($urandom_range(7) == 0) ? pick_word() : $urandom_range(200 * 65536);
		f.wheel_rl = ($urandom_range(7) == 0) ? pick_word() : $urandom_range(200 * 65536);
		f.wheel_rr = ($urandom_range(7) == 0) ? pick_word() : $urandom_range(200 * 65536);
		f.long_accel = ($urandom_range(7) == 0) ? pick_word()
			: $signed($urandom_range(20 * 65536)) - 10 * 65536;
		f.yaw_rate = ($urandom_range(7) == 0) ? pick_word()
			: $signed($urandom_range(4 * 65536)) - 2 * 65536;
		f.frame_latency = ($urandom_range(5) == 0) ? pick_word()
			: $urandom_range(2 * 65536);
		return f;
	endfunction

	task automatic rand_config(bit extreme);
		write_reg(sff_pkg::REG_LATENCY_LIMIT,
			extreme ? 32'hFFFF_FFFF : $urandom_range(3 * 65536));
		write_reg(sff_pkg::REG_SLEW_SPEED,
			extreme ? 32'h7FFF_FFFF : $urandom_range(4 * 65536));
		write_reg(sff_pkg::REG_CENTER_GAIN,
			extreme ? 32'hFFFF_FFFF : $urandom_range(1 << 25));
		write_reg(sff_pkg::REG_DAMP_GAIN, extreme ? 32'hFFFF_FFFF : $urandom);
		write_reg(sff_pkg::REG_SPEED_WEIGHT,
			extreme ? 32'hFFFF_FFFF : $urandom_range(1 << 26));
		write_reg(sff_pkg::REG_ACCEL_WEIGHT,
			extreme ? 32'hFFFF_FFFF : $urandom_range(1 << 26));
		write_reg(sff_pkg::REG_YAW_WEIGHT,
			extreme ? 32'hFFFF_FFFF : $urandom_range(1 << 26));
		write_reg(sff_pkg::REG_TORQUE_LIMIT,
			extreme ? 32'hFFFF_FFFF : $urandom_range(200 * 65536));
	endtask

	function automatic row_t make_row(logic [31:0] cmd, logic [31:0] meas,
		logic [31:0] whl, logic [31:0] acc, logic [31:0] yaw, logic [31:0] lat);
		row_t r;
		r.frame = {cmd, meas, whl, whl, whl, whl, acc, yaw, lat};
		r.known = 1'b0;
		r.want  = '0;
		return r;
	endfunction

	// result side: random stall and compare at the rising edge
	always @(posedge clk) begin
		sff_pkg::out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (frame_q.size() == 0) begin
				$display("%0t: result with none expected, got %h", $time, out_data);
				errors++;
			end else begin
				want = frame_q.pop_front();
				if (out_data.center_torque !== want.center_torque) begin
					$display("%0t: center_torque expected %h got %h", $time,
						want.center_torque, out_data.center_torque);
					errors++;
				end
				if (out_data.left_cue !== want.left_cue) begin
					$display("%0t: left_cue expected %h got %h", $time,
						want.left_cue, out_data.left_cue);
					errors++;
				end
				if (out_data.right_cue !== want.right_cue) begin
					$display("%0t: right_cue expected %h got %h", $time,
						want.right_cue, out_data.right_cue);
					errors++;
				end
				if (out_data.mean_speed !== want.mean_speed) begin
					$display("%0t: mean_speed expected %h got %h", $time,
						want.mean_speed, out_data.mean_speed);
					errors++;
				end
			end
		end
	end

	always @(negedge clk) out_stall <= (recv_idle != 0) && ($urandom_range(99) < recv_idle);

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("steering_force_feedback_unit_test: done, errors");
			$finish;
		end
	end

	initial begin
		row_t r;
		sff_pkg::out_t zero_out;
		clk = 1'b0;
		errors = 0;
		cycles = 0;
		send_idle = 0;
		recv_idle = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		lat_lim = 65536; slew = 65536; g_center = 41943; g_damp = 41943;
		w_speed = 168; w_accel = 168; w_yaw = 168; trq_lim = 6553600;
		prev_cmd = 0; acc_lim = 0; acc_sm = 0; spd_sm = 0; yaw_sm = 0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// all-zero frame after reset gives all-zero result
		zero_out = '0;
		r = make_row(0, 0, 0, 0, 0, 0);
		r.known = 1'b1;
		r.want = zero_out;
		rows = {rows, r};
		rows = {rows, make_row(32'h0001_0000, 0, 32'h0064_0000, 32'h0002_0000, 32'h0001_0000,
			32'h0000_8000)};
		rows = {rows, make_row(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF)};
		rows = {rows, make_row(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000)};
		// negative latency, latency above limit, diff inside the deadband
		rows = {rows, make_row(32'h0010_0000, 32'h000F_0000, 32'h0032_0000, 0, 0, 32'hFFFF_0000)};
		rows = {rows, make_row(32'h0020_0000, 0, 32'h0032_0000, 32'hFFFE_0000, 0, 32'h0005_0000)};
		rows = {rows, make_row(32'h0020_8000, 32'h0020_0000, 32'h0032_0000, 0, 0, 32'h0000_4000)};
		rows = {rows, make_row(32'hFFE0_0000, 32'h0030_0000, 32'h0032_0000, 32'h0010_0000,
			32'hFFF0_0000, 32'h0001_0000)};
		rows = {rows, make_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF)};
		rows = {rows, make_row(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
			32'h5555_5555, 32'hAAAA_AAAA)};
		rows = {rows, make_row(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
			32'hAAAA_AAAA, 32'h5555_5555)};
		foreach (rows[i]) send_frame(rows[i].frame, rows[i].known, rows[i].want);
		wait_drained();

		// saturating settings: cues and torque overflow
		rand_config(1'b1);
		for (int i = 0; i < 12; i++) send_frame(rand_frame(), 1'b0, zero_out);
		wait_drained();
		write_reg(sff_pkg::REG_LATENCY_LIMIT, 0);
		write_reg(sff_pkg::REG_SLEW_SPEED, 0);
		write_reg(sff_pkg::REG_CENTER_GAIN, 0);
		write_reg(sff_pkg::REG_DAMP_GAIN, 0);
		write_reg(sff_pkg::REG_SPEED_WEIGHT, 0);
		write_reg(sff_pkg::REG_ACCEL_WEIGHT, 0);
		write_reg(sff_pkg::REG_YAW_WEIGHT, 0);
		write_reg(sff_pkg::REG_TORQUE_LIMIT, 0);
		for (int i = 0; i < 8; i++) send_frame(rand_frame(), 1'b0, zero_out);
		wait_drained();

		for (int ph = 0; ph < 6; ph++) begin
			rand_config(1'b0);
			send_idle = (ph < 2) ? 26 : (ph < 4) ? 49 : 0;
			recv_idle = (ph < 2) ? 49 : (ph < 4) ? 26 : 0;
			for (int i = 0; i < 170; i++) send_frame(rand_frame(), 1'b0, zero_out);
			send_idle = 0;
			recv_idle = 0;
			wait_drained();
		end

		if (errors == 0 && frame_q.size() == 0)
			$display("steering_force_feedback_unit_test: done, clean");
		else
			$display("steering_force_feedback_unit_test: done, errors");
		$finish;
	end

endmodule
